### rtl/sgpg_pkg.sv
package sgpg_pkg;

  localparam int PixelW    = 12;
  localparam int PhaseW    = 27;
  localparam int ContrastW = 16;
  localparam int LumW      = 16;
  localparam int GrayW     = 8;
  localparam int ArgbW     = 32;
  localparam int MagW      = 15;
  localparam int AddrW     = 4;
  localparam int DataW     = 32;

  localparam logic [1:0] RegPhaseStep = 2'd0;
  localparam logic [1:0] RegContrast  = 2'd1;
  localparam logic [1:0] RegLuminance = 2'd2;

  localparam logic [PhaseW-1:0]    PhaseStepReset = 27'd1887437;
  localparam logic [ContrastW-1:0] ContrastReset  = 16'd32512;
  localparam logic [LumW-1:0]      LuminanceReset = 16'd32640;

  localparam logic [7:0]       AlphaOpaque = 8'hff;
  localparam logic [GrayW-1:0] GrayMax     = 8'd255;

  localparam logic [63:0] PiQ30 = 64'd3373259426;

  localparam logic [63:0] TaylorDiv [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef struct packed {
    logic [PhaseW-1:0]    phase_step;
    logic [ContrastW-1:0] contrast;
    logic [LumW-1:0]      luminance;
  } cfg_t;

  // Sine of an angle in the first quadrant given with 30 fractional bits,
  // returned as a Q0.15 magnitude saturated to the largest positive code.
  function automatic logic [MagW-1:0] quarter_sine(input logic [63:0] theta);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    x2   = (theta * theta) >> 30;
    term = theta;
    sum  = theta;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / TaylorDiv[k-1];
      if (k[0]) begin
        sum = (sum >= term) ? (sum - term) : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[MagW-1:0];
  endfunction

endpackage

### rtl/sine_grating_pixel_generator_top.sv
// Produces one pixel of a vertical sine grating per pixel column, taking one
// transfer per clock and giving one result transfer per clock for as long as
// the output is not stalled. Each item passes through registered steps in
// order: the column times phase step product and its reduction to a table
// index, the quarter-wave fold and the registered sine table read, and the
// contrast multiply and the luminance add with rounding and clamping. The
// sine table is fixed at elaboration, so there is no start-up pass after
// reset, and the phase step, contrast and luminance registers may be written
// only while no item is in flight.
module sine_grating_pixel_generator_top #(
  parameter int TABLE_STEPS_PER_DEGREE = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgpg_pkg::AddrW-1:0]     paddr,
  input  logic [sgpg_pkg::DataW-1:0]     pwdata,
  output logic [sgpg_pkg::DataW-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sgpg_pkg::PixelW-1:0]    pixel_x_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sgpg_pkg::GrayW-1:0]     gray_o,
  output logic [sgpg_pkg::ArgbW-1:0]     argb_word_o,
  output logic                           clamped_o
);

  localparam int IdxW = $clog2(360 * TABLE_STEPS_PER_DEGREE);

  sgpg_pkg::cfg_t            cfg;
  logic                      idx_valid;
  logic                      idx_stall;
  logic [IdxW-1:0]           idx;
  logic                      sin_valid;
  logic                      sin_stall;
  logic [sgpg_pkg::MagW-1:0] mag;
  logic                      neg;

  sgpg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sgpg_index #(
    .TABLE_STEPS_PER_DEGREE (TABLE_STEPS_PER_DEGREE),
    .IdxW                   (IdxW)
  ) u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .phase_step_i (cfg.phase_step),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_x_i    (pixel_x_i),
    .out_valid_o  (idx_valid),
    .out_stall_i  (idx_stall),
    .idx_o        (idx)
  );

  sgpg_sine #(
    .TABLE_STEPS_PER_DEGREE (TABLE_STEPS_PER_DEGREE),
    .IdxW                   (IdxW)
  ) u_sine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (idx_valid),
    .in_stall_o  (idx_stall),
    .idx_i       (idx),
    .out_valid_o (sin_valid),
    .out_stall_i (sin_stall),
    .mag_o       (mag),
    .neg_o       (neg)
  );

  sgpg_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .contrast_i  (cfg.contrast),
    .luminance_i (cfg.luminance),
    .in_valid_i  (sin_valid),
    .in_stall_o  (sin_stall),
    .mag_i       (mag),
    .neg_i       (neg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gray_o      (gray_o),
    .clamped_o   (clamped_o)
  );

  assign argb_word_o = {sgpg_pkg::AlphaOpaque, gray_o, gray_o, gray_o};

endmodule

### rtl/sgpg_cfg.sv
module sgpg_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sgpg_pkg::AddrW-1:0]  paddr,
  input  logic [sgpg_pkg::DataW-1:0]  pwdata,
  output logic [sgpg_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output sgpg_pkg::cfg_t              cfg_o
);

  sgpg_pkg::cfg_t cfg_q;
  sgpg_pkg::cfg_t cfg_d;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        sgpg_pkg::RegPhaseStep: cfg_d.phase_step = pwdata[sgpg_pkg::PhaseW-1:0];
        sgpg_pkg::RegContrast:  cfg_d.contrast   = pwdata[sgpg_pkg::ContrastW-1:0];
        sgpg_pkg::RegLuminance: cfg_d.luminance  = pwdata[sgpg_pkg::LumW-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step <= sgpg_pkg::PhaseStepReset;
      cfg_q.contrast   <= sgpg_pkg::ContrastReset;
      cfg_q.luminance  <= sgpg_pkg::LuminanceReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      sgpg_pkg::RegPhaseStep: prdata = sgpg_pkg::DataW'(cfg_q.phase_step);
      sgpg_pkg::RegContrast:  prdata = sgpg_pkg::DataW'(cfg_q.contrast);
      sgpg_pkg::RegLuminance: prdata = sgpg_pkg::DataW'(cfg_q.luminance);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/sgpg_index.sv
module sgpg_index #(
  parameter int TABLE_STEPS_PER_DEGREE = 4,
  parameter int IdxW = $clog2(360 * TABLE_STEPS_PER_DEGREE)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sgpg_pkg::PhaseW-1:0]  phase_step_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sgpg_pkg::PixelW-1:0]  pixel_x_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [IdxW-1:0]              idx_o
);

  localparam int TableSize = 360 * TABLE_STEPS_PER_DEGREE;
  localparam int ProdW     = sgpg_pkg::PixelW + sgpg_pkg::PhaseW;
  localparam int PosW      = ProdW - 16;
  localparam int RecipW    = PosW + 1;
  localparam int QuotW     = PosW - IdxW + 1;
  localparam int RecipSh   = PosW + IdxW;
  localparam int QtW       = QuotW + IdxW + 1;
  localparam logic [63:0] Recip = (64'd1 << RecipSh) / 64'(TableSize);

  logic va_q, vb_q, vc_q, vd_q;
  logic en_a, en_b, en_c, en_d;

  logic [ProdW-1:0]         prod_q;
  logic [PosW-1:0]          pos_q;
  logic [PosW+RecipW-1:0]   qmul_q;
  logic [IdxW:0]            plo_q;
  logic [IdxW:0]            qtlo_q;
  logic [IdxW-1:0]          idx_q;

  logic [PosW-1:0]          pos_d;
  logic [QuotW-1:0]         quot;
  logic [QtW-1:0]           qt_full;
  logic [IdxW:0]            rem;
  logic [IdxW-1:0]          idx_d;

  assign en_d = !vd_q || !out_stall_i;
  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign in_stall_o = !en_a;

  assign pos_d   = prod_q[ProdW-1:16];
  assign quot    = qmul_q[PosW+RecipW-1:RecipSh];
  assign qt_full = QtW'(quot) * QtW'(TableSize);
  assign rem     = plo_q - qtlo_q;

  always_comb begin
    if (rem >= (IdxW+1)'(TableSize)) begin
      idx_d = IdxW'(rem - (IdxW+1)'(TableSize));
    end else begin
      idx_d = rem[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= in_valid_i;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
      if (en_d) begin
        vd_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      prod_q <= ProdW'(pixel_x_i) * ProdW'(phase_step_i);
    end
    if (en_b && va_q) begin
      pos_q  <= pos_d;
      qmul_q <= (PosW+RecipW)'(pos_d) * (PosW+RecipW)'(Recip[RecipW-1:0]);
    end
    if (en_c && vb_q) begin
      plo_q  <= pos_q[IdxW:0];
      qtlo_q <= qt_full[IdxW:0];
    end
    if (en_d && vc_q) begin
      idx_q <= idx_d;
    end
  end

  assign out_valid_o = vd_q;
  assign idx_o       = idx_q;

endmodule

### rtl/sgpg_sine.sv
module sgpg_sine #(
  parameter int TABLE_STEPS_PER_DEGREE = 4,
  parameter int IdxW = $clog2(360 * TABLE_STEPS_PER_DEGREE)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [IdxW-1:0]            idx_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sgpg_pkg::MagW-1:0]  mag_o,
  output logic                       neg_o
);

  localparam int Half    = 180 * TABLE_STEPS_PER_DEGREE;
  localparam int Quarter = 90 * TABLE_STEPS_PER_DEGREE;
  localparam int RW      = $clog2(Quarter + 1);

  logic [sgpg_pkg::MagW-1:0] rom [Quarter+1];

  for (genvar g = 0; g <= Quarter; g++) begin : g_rom
    localparam logic [63:0] Theta = (sgpg_pkg::PiQ30 * 64'(g)) / 64'(Half);
    assign rom[g] = sgpg_pkg::quarter_sine(Theta);
  end

  logic ve_q, vf_q;
  logic en_e, en_f;
  logic                      upper;
  logic [IdxW-1:0]           j;
  logic [RW-1:0]             r_d;
  logic [RW-1:0]             r_q;
  logic                      nege_q;
  logic                      negf_q;
  logic [sgpg_pkg::MagW-1:0] mag_q;

  assign en_f = !vf_q || !out_stall_i;
  assign en_e = !ve_q || en_f;
  assign in_stall_o = !en_e;

  assign upper = idx_i >= IdxW'(Half);
  assign j     = upper ? (idx_i - IdxW'(Half)) : idx_i;
  assign r_d   = (j <= IdxW'(Quarter)) ? RW'(j) : RW'(IdxW'(Half) - j);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (en_e) begin
        ve_q <= in_valid_i;
      end
      if (en_f) begin
        vf_q <= ve_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e && in_valid_i) begin
      r_q    <= r_d;
      nege_q <= upper;
    end
    if (en_f && ve_q) begin
      mag_q  <= rom[r_q];
      negf_q <= nege_q;
    end
  end

  assign out_valid_o = vf_q;
  assign mag_o       = mag_q;
  assign neg_o       = negf_q;

endmodule

### rtl/sgpg_shade.sv
module sgpg_shade (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sgpg_pkg::ContrastW-1:0] contrast_i,
  input  logic [sgpg_pkg::LumW-1:0]      luminance_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sgpg_pkg::MagW-1:0]      mag_i,
  input  logic                           neg_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sgpg_pkg::GrayW-1:0]     gray_o,
  output logic                           clamped_o
);

  localparam int MW = sgpg_pkg::MagW + sgpg_pkg::ContrastW;
  localparam int TW = 34;
  localparam int VW = TW - 23;

  logic vg_q, vh_q;
  logic en_g, en_h;

  logic [MW-1:0]              m_q;
  logic                       pos_q;
  logic                       neg_q;
  logic [sgpg_pkg::GrayW-1:0] gray_q;
  logic                       clamped_q;

  logic signed [TW-1:0]       lum_t;
  logic signed [TW-1:0]       sm;
  logic signed [TW-1:0]       bias;
  logic signed [TW-1:0]       t;
  logic signed [VW-1:0]       v;
  logic [sgpg_pkg::GrayW-1:0] gray_d;
  logic                       clamped_d;

  assign en_h = !vh_q || !out_stall_i;
  assign en_g = !vg_q || en_h;
  assign in_stall_o = !en_g;

  assign lum_t = TW'({luminance_i, 15'd0});
  assign sm    = neg_q ? -TW'(m_q) : TW'(m_q);
  assign bias  = pos_q ? TW'(35'sd4194304) : -TW'(35'sd4194304);
  assign t     = lum_t + sm + bias;
  assign v     = VW'(t >>> 23);

  always_comb begin
    if (v[VW-1]) begin
      gray_d    = '0;
      clamped_d = 1'b1;
    end else if (|v[VW-2:sgpg_pkg::GrayW]) begin
      gray_d    = sgpg_pkg::GrayMax;
      clamped_d = 1'b1;
    end else begin
      gray_d    = v[sgpg_pkg::GrayW-1:0];
      clamped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
      vh_q <= 1'b0;
    end else begin
      if (en_g) begin
        vg_q <= in_valid_i;
      end
      if (en_h) begin
        vh_q <= vg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_g && in_valid_i) begin
      m_q   <= MW'(mag_i) * MW'(contrast_i);
      pos_q <= (mag_i != '0) && !neg_i;
      neg_q <= neg_i;
    end
    if (en_h && vg_q) begin
      gray_q    <= gray_d;
      clamped_q <= clamped_d;
    end
  end

  assign out_valid_o = vh_q;
  assign gray_o      = gray_q;
  assign clamped_o   = clamped_q;

endmodule
